// ===== design/itoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, widths and character tables for the integer-to-ASCII unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W        = 33;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 6;
    localparam int QUOT_W         = 32;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 32;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS_PER_CYC = 4;
    localparam int DIV_CYCLES       = QUOT_W / DIV_BITS_PER_CYC;
    localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [CHAR_W-1:0] LOWER_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [CHAR_W-1:0] UPPER_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_SIGN,
        S_FETCH,
        S_SHOW
    } t_state;

    typedef struct packed {
        logic                start;
        logic [QUOT_W-1:0]   dividend;
        logic [RADIX_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quotient;
        logic [DIGIT_W-1:0]  remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d,
                                                 input logic lower);
        if (lower) begin
            return LOWER_GLYPHS[d];
        end
        return UPPER_GLYPHS[d];
    endfunction

endpackage

// ===== design/itoa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels: number request in, character beats out.
// ----------------------------------------------------------------------------
interface itoa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [itoa_pkg::VALUE_W-1:0] value;
    logic        [itoa_pkg::RADIX_W-1:0] radix;
    logic                                lower_case;

    modport source (output valid, output value, output radix, output lower_case,
                    input ready);
    modport sink   (input valid, input value, input radix, input lower_case,
                    output ready);
endinterface

interface itoa_out_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CHAR_W-1:0]   character;
    logic                          last;
    logic [itoa_pkg::COUNT_W-1:0]  char_count;

    modport source (output valid, output character, output last, output char_count,
                    input ready);
    modport sink   (input valid, input character, input last, input char_count,
                    output ready);
endinterface

// ===== design/itoa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_div
// Iterative restoring divider, 32-bit dividend by a base of 2..16.
// Retires DIV_BITS_PER_CYC quotient bits per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module itoa_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itoa_pkg::t_div_req  i_req,
    output itoa_pkg::t_div_rsp  o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [itoa_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [itoa_pkg::QUOT_W-1:0]         r_q;
    logic [itoa_pkg::DIGIT_W-1:0]        r_rem;
    logic [itoa_pkg::RADIX_W-1:0]        r_div;

    logic [itoa_pkg::QUOT_W-1:0]         n_q;
    logic [itoa_pkg::DIGIT_W-1:0]        n_rem;
    logic [itoa_pkg::DIGIT_W:0]          w_trial;
    logic                                w_ge;

    // dividend shifts out the top while quotient bits shift in the bottom
    always_comb begin
        n_q     = r_q;
        n_rem   = r_rem;
        w_trial = '0;
        w_ge    = 1'b0;
        for (int j = 0; j < itoa_pkg::DIV_BITS_PER_CYC; j++) begin
            w_trial = {n_rem, n_q[itoa_pkg::QUOT_W-1]};
            w_ge    = (w_trial >= r_div);
            n_q     = {n_q[itoa_pkg::QUOT_W-2:0], w_ge};
            if (w_ge) begin
                n_rem = itoa_pkg::DIGIT_W'(w_trial - r_div);
            end else begin
                n_rem = w_trial[itoa_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == itoa_pkg::DIV_CNT_W'(itoa_pkg::DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== design/integer_to_ascii_radix_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_unit
// Converts a signed number to ASCII text in base 2..16, one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one beat carries value (33-bit signed), radix and lower_case.
//           Radix below 2 acts as 2, above 16 as 16. Ready is high only
//           while the unit is idle.
//   o_out : the text, most significant digit first, a leading '-' for
//           negative values. The final beat has last set and char_count
//           holding the number of characters, sign included; other beats
//           carry a count of zero.
// Sequence:
//   Digits come from repeated division by the divider, one division per
//   digit (start, 8 steps of 4 bits, done). After the last division a
//   minus sign goes out first when negative; the digits are then read back
//   from the digit memory, a registered read, then the beat, per character.
// Reset and stalls:
//   Reset returns the sequencer to idle; any conversion in flight is dropped.
//   A stalled output beat holds its payload until taken; the next character
//   is fetched only after that.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_unit #(
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    itoa_in_if.sink         i_in,
    itoa_out_if.source      o_out
);

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    itoa_pkg::t_state                  r_state, n_state;
    logic [itoa_pkg::QUOT_W-1:0]       r_quot, n_quot;
    logic [itoa_pkg::RADIX_W-1:0]      r_base, n_base;
    logic                              r_neg, n_neg;
    logic                              r_case, n_case;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [IW-1:0]                     r_idx, n_idx;
    logic [itoa_pkg::DIGIT_W-1:0]      r_rd;
    logic                              w_we;
    logic [itoa_pkg::QUOT_W:0]         w_mag;
    logic [CW:0]                       w_total;
    logic                              w_out_fire;

    logic [itoa_pkg::DIGIT_W-1:0]      mem [MAX_DIGITS];

    itoa_pkg::t_div_req                w_div_req;
    itoa_pkg::t_div_rsp                w_div_rsp;

    itoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_div_req.start    = (r_state == itoa_pkg::S_START);
    assign w_div_req.dividend = r_quot;
    assign w_div_req.divisor  = r_base;

    assign w_mag      = i_in.value[itoa_pkg::VALUE_W-1] ? -i_in.value : i_in.value;
    assign w_out_fire = o_out.valid && o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = itoa_pkg::S_START;
                end
            end
            itoa_pkg::S_START: begin
                n_state = itoa_pkg::S_WAIT;
            end
            itoa_pkg::S_WAIT: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quotient != '0) begin
                        n_state = itoa_pkg::S_START;
                    end else if (r_neg) begin
                        n_state = itoa_pkg::S_SIGN;
                    end else begin
                        n_state = itoa_pkg::S_FETCH;
                    end
                end
            end
            itoa_pkg::S_SIGN: begin
                if (o_out.ready) begin
                    n_state = itoa_pkg::S_FETCH;
                end
            end
            itoa_pkg::S_FETCH: begin
                n_state = itoa_pkg::S_SHOW;
            end
            itoa_pkg::S_SHOW: begin
                if (o_out.ready) begin
                    n_state = (r_idx == '0) ? itoa_pkg::S_IDLE : itoa_pkg::S_FETCH;
                end
            end
            default: begin
                n_state = itoa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb begin
        n_quot = r_quot;
        n_base = r_base;
        n_neg  = r_neg;
        n_case = r_case;
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        w_we   = 1'b0;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_quot = w_mag[itoa_pkg::QUOT_W-1:0];
                    n_neg  = i_in.value[itoa_pkg::VALUE_W-1];
                    n_case = i_in.lower_case;
                    n_cnt  = '0;
                    if (i_in.radix < itoa_pkg::RADIX_MIN) begin
                        n_base = itoa_pkg::RADIX_MIN;
                    end else if (i_in.radix > itoa_pkg::RADIX_MAX) begin
                        n_base = itoa_pkg::RADIX_MAX;
                    end else begin
                        n_base = i_in.radix;
                    end
                end
            end
            itoa_pkg::S_WAIT: begin
                if (w_div_rsp.done) begin
                    n_quot = w_div_rsp.quotient;
                    // digits beyond the store are dropped, low digits kept
                    if (r_cnt < CW'(MAX_DIGITS)) begin
                        w_we  = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_idx = IW'(n_cnt - 1'b1);
                end
            end
            itoa_pkg::S_SHOW: begin
                if (o_out.ready && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_base <= n_base;
        r_neg  <= n_neg;
        r_case <= n_case;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_cnt[IW-1:0]] <= w_div_rsp.remainder;
        end
        r_rd <= mem[r_idx];
    end

    assign w_total = {1'b0, r_cnt} + (CW+1)'(r_neg);

    assign i_in.ready       = (r_state == itoa_pkg::S_IDLE);
    assign o_out.valid      = (r_state == itoa_pkg::S_SIGN) || (r_state == itoa_pkg::S_SHOW);
    assign o_out.character  = (r_state == itoa_pkg::S_SIGN) ? itoa_pkg::CHAR_MINUS
                                                            : itoa_pkg::glyph(r_rd, r_case);
    assign o_out.last       = (r_state == itoa_pkg::S_SHOW) && (r_idx == '0);
    assign o_out.char_count = o_out.last ? itoa_pkg::COUNT_W'(w_total) : '0;

    // no new request while text is still going out
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.valid && i_in.ready && o_out.valid))
        else $error("request accepted while output beat pending");

    // divider results only arrive while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == itoa_pkg::S_WAIT))
        else $error("divider done outside wait state");

    // the final beat returns the unit to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out.last) |=> (r_state == itoa_pkg::S_IDLE))
        else $error("unit not idle after final beat");

    // at least one digit is stored when the final beat goes out
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (r_cnt != '0))
        else $error("final beat without digits");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_ascii_radix_unit. A local model turns
// each accepted number into its expected character beats; a monitor checks
// every output beat against them in order. Directed cases cover zero, the
// extremes, the radix clamps and letter case; random numbers follow under
// bursty input traffic and randomised output back-pressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int MAX_PRINTS     = 30;
    localparam int RANDOM_ITEMS   = 388;

    localparam logic [itoa_pkg::CHAR_W-1:0] CHAR_ZERO  = "0";
    localparam logic [itoa_pkg::CHAR_W-1:0] CHAR_LOW_A = "a";
    localparam logic [itoa_pkg::CHAR_W-1:0] CHAR_UP_A  = "A";

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_BURSTY
    } t_rx_mode;

    typedef struct packed {
        logic [itoa_pkg::CHAR_W-1:0]  character;
        logic                         last;
        logic [itoa_pkg::COUNT_W-1:0] char_count;
    } t_text_beat;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if  num_ch ();
    itoa_out_if text_ch ();

    integer_to_ascii_radix_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (text_ch)
    );

    t_text_beat expected_text [$];

    int error_count    = 0;
    int numbers_sent   = 0;
    int negatives_sent = 0;
    int chars_checked  = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_low  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic logic [itoa_pkg::CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                                input logic lc);
        if (d < 4'd10) begin
            return CHAR_ZERO + itoa_pkg::CHAR_W'(d);
        end
        return (lc ? CHAR_LOW_A : CHAR_UP_A) + itoa_pkg::CHAR_W'(d - 4'd10);
    endfunction

    // Expected text for one number: optional '-', then digits MSB first.
    function automatic void predict_text(input logic [itoa_pkg::VALUE_W-1:0] raw,
                                         input logic [itoa_pkg::RADIX_W-1:0] radix_in,
                                         input logic lc);
        logic [itoa_pkg::VALUE_W-1:0] mag;
        logic [itoa_pkg::QUOT_W-1:0]  quot;
        logic [itoa_pkg::RADIX_W-1:0] base;
        logic [3:0]                   digits [$];
        logic                         neg;
        int                           total;
        t_text_beat                   beat;

        neg  = raw[itoa_pkg::VALUE_W-1];
        mag  = neg ? (~raw + 1'b1) : raw;
        quot = mag[itoa_pkg::QUOT_W-1:0];
        base = radix_in;
        if (base < itoa_pkg::RADIX_MIN) begin
            base = itoa_pkg::RADIX_MIN;
        end
        if (base > itoa_pkg::RADIX_MAX) begin
            base = itoa_pkg::RADIX_MAX;
        end
        do begin
            digits.push_back(4'(quot % base));
            quot = quot / base;
        end while (quot != 0);
        total = digits.size() + (neg ? 1 : 0);
        if (neg) begin
            beat = '{character: itoa_pkg::CHAR_MINUS, last: 1'b0, char_count: '0};
            expected_text.push_back(beat);
        end
        for (int i = digits.size() - 1; i >= 0; i--) begin
            beat.character  = digit_char(digits[i], lc);
            beat.last       = (i == 0);
            beat.char_count = (i == 0) ? itoa_pkg::COUNT_W'(total) : '0;
            expected_text.push_back(beat);
        end
    endfunction

    // Called at a rising edge; returns at the edge that took the beat.
    task automatic send_number(input logic [itoa_pkg::VALUE_W-1:0] v,
                               input logic [itoa_pkg::RADIX_W-1:0] r,
                               input logic lc);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                num_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        num_ch.valid      <= 1'b1;
        num_ch.value      <= v;
        num_ch.radix      <= r;
        num_ch.lower_case <= lc;
        do @(negedge i_clk); while (num_ch.ready !== 1'b1);
        @(posedge i_clk);
        predict_text(v, r, lc);
        numbers_sent++;
        if (v[itoa_pkg::VALUE_W-1]) begin
            negatives_sent++;
        end
        burst_left--;
    endtask

    task automatic wait_text_drained();
        num_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [itoa_pkg::VALUE_W-1:0] random_number();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2: return itoa_pkg::VALUE_W'($urandom_range(0, 999));
            3, 4:    return {1'b0, 32'($urandom())};
            5, 6:    return {2'b11, 31'($urandom())};
            7:       return itoa_pkg::VALUE_W'(-int'($urandom_range(1, 999)));
            8:       return {1'($urandom_range(0, 1)), 32'($urandom())};
            default: begin
                k = $urandom_range(0, 32);
                if ($urandom_range(0, 1) == 1) begin
                    return -(itoa_pkg::VALUE_W'(1) << k);
                end
                return (itoa_pkg::VALUE_W'(1) << k) -
                       itoa_pkg::VALUE_W'($urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic test_zero_and_extremes();
        send_number(itoa_pkg::VALUE_W'(0), 5'd10, 1'b0);
        send_number(itoa_pkg::VALUE_W'(0), 5'd2, 1'b1);
        send_number(itoa_pkg::VALUE_W'(1), 5'd2, 1'b0);
        send_number(itoa_pkg::VALUE_W'(-1), 5'd16, 1'b1);
        send_number(itoa_pkg::VALUE_W'(-64'sd2147483648), 5'd10, 1'b0);
        send_number(itoa_pkg::VALUE_W'(-64'sd2147483648), 5'd2, 1'b0);
        send_number({1'b0, 32'hFFFF_FFFF}, 5'd2, 1'b1);
        send_number({1'b0, 32'hFFFF_FFFF}, 5'd16, 1'b1);
        send_number({1'b0, 32'hFFFF_FFFF}, 5'd16, 1'b0);
        send_number({1'b0, 32'h7FFF_FFFF}, 5'd10, 1'b0);
        // below the signed int range: magnitude wraps, -2^32 gives "-0"
        send_number({1'b1, 32'h0000_0000}, 5'd10, 1'b0);
        send_number({1'b1, 32'h7FFF_FFFF}, 5'd16, 1'b0);
    endtask

    task automatic test_radix_clamping();
        send_number(itoa_pkg::VALUE_W'(255), 5'd0, 1'b0);
        send_number(itoa_pkg::VALUE_W'(255), 5'd1, 1'b1);
        send_number(itoa_pkg::VALUE_W'(-255), 5'd17, 1'b1);
        send_number(itoa_pkg::VALUE_W'(48879), 5'd31, 1'b0);
        send_number(itoa_pkg::VALUE_W'(-100), 5'd3, 1'b0);
    endtask

    task automatic test_letter_case();
        send_number(itoa_pkg::VALUE_W'(32'hABCDEF), 5'd16, 1'b1);
        send_number(itoa_pkg::VALUE_W'(32'hABCDEF), 5'd16, 1'b0);
        send_number(itoa_pkg::VALUE_W'(-12345678), 5'd13, 1'b1);
        send_number(itoa_pkg::VALUE_W'(120), 5'd11, 1'b0);
        send_number({1'b0, 32'hFEDC_BA98}, 5'd15, 1'b1);
    endtask

    task automatic test_random_numbers(input int n);
        logic [itoa_pkg::RADIX_W-1:0] r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                r = itoa_pkg::RADIX_W'($urandom_range(2, 16));
            end else begin
                r = itoa_pkg::RADIX_W'($urandom_range(0, 31));
            end
            send_number(random_number(), r, 1'($urandom_range(0, 1)));
        end
    endtask

    // Receiver back-pressure: open, coin-flip, or long stalls, switched now and then.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (rx_mode)
            RX_OPEN: begin
                text_ch.ready <= 1'b1;
            end
            RX_COIN: begin
                text_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (hold_left == 0) begin
                    hold_low  = !hold_low;
                    hold_left = hold_low ? $urandom_range(1, 30) : $urandom_range(1, 10);
                end
                hold_left--;
                text_ch.ready <= !hold_low;
            end
        endcase
    end

    always @(negedge i_clk) begin : text_check
        t_text_beat want;
        if (i_rst_n === 1'b1 && text_ch.valid === 1'b1 && text_ch.ready === 1'b1) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected beat char=%h last=%b count=%0d",
                                          text_ch.character, text_ch.last,
                                          text_ch.char_count));
            end else begin
                want = expected_text.pop_front();
                if (text_ch.character !== want.character) begin
                    report_mismatch($sformatf("character got %h want %h",
                                              text_ch.character, want.character));
                end
                if (text_ch.last !== want.last) begin
                    report_mismatch($sformatf("last got %b want %b (char %h)",
                                              text_ch.last, want.last, want.character));
                end
                if (text_ch.char_count !== want.char_count) begin
                    report_mismatch($sformatf("char_count got %0d want %0d",
                                              text_ch.char_count, want.char_count));
                end
                chars_checked++;
            end
        end
    end

    // No beat on either side for too long means the unit is hung.
    always @(negedge i_clk) begin
        if ((num_ch.valid === 1'b1 && num_ch.ready === 1'b1) ||
            (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $realtime, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        num_ch.valid      <= 1'b0;
        num_ch.value      <= '0;
        num_ch.radix      <= itoa_pkg::RADIX_MIN;
        num_ch.lower_case <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_and_extremes();
        test_radix_clamping();
        test_letter_case();
        test_random_numbers(RANDOM_ITEMS);
        wait_text_drained();

        if (expected_text.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      expected_text.size()));
        end
        $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
                 numbers_sent, negatives_sent, chars_checked);
        $display("radix 0..31, both letter cases, bursty input and stalled output.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
